FILE: src/soa_pkg.sv
`timescale 1ns / 1ps

package soa_pkg;

    localparam int BASE_W     = 32;
    localparam int OBJ_SIZE_W = 16;
    localparam int SLAB_W     = 24;
    localparam int OPS_W      = 9;
    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 4;
    localparam int PORT_AW    = 32;

    localparam logic [BASE_W-1:0]     RST_REGION_BASE      = 32'd0;
    localparam logic [OBJ_SIZE_W-1:0] RST_OBJECT_SIZE      = 16'd64;
    localparam logic [SLAB_W-1:0]     RST_SLAB_SIZE        = 24'd4096;
    localparam logic [OPS_W-1:0]      RST_OBJECTS_PER_SLAB = 9'd64;

    typedef enum logic [1:0] {
        REG_REGION_BASE      = 2'd0,
        REG_OBJECT_SIZE      = 2'd1,
        REG_SLAB_SIZE        = 2'd2,
        REG_OBJECTS_PER_SLAB = 2'd3
    } reg_idx_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_OOM         = 3'd1,
        ST_UNALIGNED   = 3'd2,
        ST_NOT_IN_SLAB = 3'd3,
        ST_INVALID     = 3'd4
    } status_t;

    typedef struct packed {
        logic [BASE_W-1:0]     region_base;
        logic [OBJ_SIZE_W-1:0] object_size;
        logic [SLAB_W-1:0]     slab_size;
        logic [OPS_W-1:0]      objects_per_slab;
    } cfg_t;

endpackage

FILE: src/slab_object_allocator_top.sv
`timescale 1ns / 1ps
// Allocate: each open slab passed over costs a count-memory read (S_A_RD) and a check (S_A_CHK);
// a slab with a free object, or a newly opened slab, then goes through S_A_MUL and S_A_ADD to S_DONE.
// Free: S_F_SCAN checks the open slabs in turn, then the serial divider finds the object index.
// One transaction at a time; the next is accepted while a result waits in the output register.
// Reset clears the open-slab count and the control state; memories need no clearing pass.
module slab_object_allocator_top
    import soa_pkg::*;
#(
    parameter int MAX_SLABS            = 16,
    parameter int MAX_OBJECTS_PER_SLAB = 256,
    parameter int ADDR_WIDTH           = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [PORT_AW-1:0] addr,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PORT_AW-1:0] obj_addr,
    output logic [2:0]         status
);

    localparam int AW        = ADDR_WIDTH;
    localparam int SIW       = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
    localparam int SUW       = $clog2(MAX_SLABS + 1);
    localparam int CW        = $clog2(MAX_OBJECTS_PER_SLAB + 1);
    localparam int PW        = (MAX_OBJECTS_PER_SLAB > 1) ? $clog2(MAX_OBJECTS_PER_SLAB) : 1;
    localparam int STK_DEPTH = MAX_SLABS * MAX_OBJECTS_PER_SLAB;
    localparam int STKAW     = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
    localparam int PRW       = PW + OBJ_SIZE_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_A_RD   = 8'b00000010,
        S_A_CHK  = 8'b00000100,
        S_A_MUL  = 8'b00001000,
        S_A_ADD  = 8'b00010000,
        S_F_SCAN = 8'b00100000,
        S_F_DIV  = 8'b01000000,
        S_DONE   = 8'b10000000
    } state_t;

    // mark: positions below it still hold their index from the slab's opening fill
    typedef struct packed {
        logic [CW-1:0] count;
        logic [CW-1:0] mark;
    } cnt_ent_t;

    cfg_t cfg;

    soa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [OBJ_SIZE_W-1:0] obj_eff;
    logic [SLAB_W-1:0]     slab_eff;
    logic [CW-1:0]         n_eff;
    logic [CW-1:0]         n_last;
    logic [63:0]           base64;
    logic [63:0]           addr64;
    logic [AW-1:0]         base_a;
    logic [AW-1:0]         addr_a;

    assign obj_eff  = (cfg.object_size == '0) ? OBJ_SIZE_W'(1) : cfg.object_size;
    assign slab_eff = (cfg.slab_size == '0) ? SLAB_W'(1) : cfg.slab_size;
    assign base64   = 64'(cfg.region_base);
    assign addr64   = 64'(addr);
    assign base_a   = base64[AW-1:0];
    assign addr_a   = addr64[AW-1:0];
    assign n_last   = n_eff - CW'(1);

    always_comb
    begin
        priority if (cfg.objects_per_slab == '0)
            n_eff = CW'(1);
        else if (32'(cfg.objects_per_slab) > 32'(MAX_OBJECTS_PER_SLAB))
            n_eff = CW'(MAX_OBJECTS_PER_SLAB);
        else
            n_eff = CW'(cfg.objects_per_slab);
    end

    state_t         state_reg, state_next;
    logic [SUW-1:0] in_use_reg, in_use_next;
    logic           out_valid_reg, out_valid_next;

    logic [SUW-1:0] slab_reg, slab_next;
    logic [AW-1:0]  start_reg, start_next;
    logic [AW-1:0]  faddr_reg, faddr_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic           use_pos_reg, use_pos_next;
    logic [PRW-1:0] prod_reg, prod_next;
    logic [AW-1:0]  res_addr_reg, res_addr_next;
    status_t        res_status_reg, res_status_next;
    logic [AW-1:0]  obj_addr_reg, obj_addr_next;
    status_t        status_reg, status_next;

    // count memory
    cnt_ent_t       cnt_mem [MAX_SLABS];
    cnt_ent_t       cnt_rd_reg;
    cnt_ent_t       cnt_wdata;
    logic           cnt_we;
    logic [SIW-1:0] cnt_addr;

    // stack memory
    logic [PW-1:0]    stk_mem [STK_DEPTH];
    logic [PW-1:0]    stk_rd_reg;
    logic [PW-1:0]    stk_wdata;
    logic             stk_we;
    logic [CW-1:0]    stk_pos;
    logic [STKAW-1:0] stk_addr;

    logic                  div_start;
    logic                  div_done;
    logic [SLAB_W-1:0]     div_quot;
    logic [OBJ_SIZE_W-1:0] div_rem;

    logic [AW-1:0] off;
    logic [63:0]   off64;
    logic [63:0]   step64;
    logic [63:0]   sum64;
    logic          in_slab;
    logic          slab_open;
    logic [CW-1:0] pop_c;
    logic          pop_fresh;
    logic [PW-1:0] idx;
    logic          out_load;

    assign cnt_addr  = slab_reg[SIW-1:0];
    assign stk_addr  = STKAW'(int'(cnt_addr) * MAX_OBJECTS_PER_SLAB + int'(stk_pos[PW-1:0]));
    assign stk_wdata = div_quot[PW-1:0];

    assign off       = faddr_reg - start_reg;
    assign off64     = 64'(off);
    assign in_slab   = off64 < 64'(slab_eff);
    assign step64    = 64'(start_reg) + 64'(slab_eff);
    assign sum64     = 64'(start_reg) + 64'(prod_reg);
    assign slab_open = slab_reg < in_use_reg;
    assign pop_c     = cnt_rd_reg.count - CW'(1);
    assign pop_fresh = pop_c < cnt_rd_reg.mark;
    assign idx       = use_pos_reg ? pos_reg[PW-1:0] : stk_rd_reg;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    soa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (off64[SLAB_W-1:0]),
        .divisor  (obj_eff),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb
    begin
        state_next      = state_reg;
        in_use_next     = in_use_reg;
        slab_next       = slab_reg;
        start_next      = start_reg;
        faddr_next      = faddr_reg;
        pos_next        = pos_reg;
        use_pos_next    = use_pos_reg;
        prod_next       = prod_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        cnt_we          = 1'b0;
        cnt_wdata       = cnt_rd_reg;
        stk_we          = 1'b0;
        stk_pos         = '0;
        div_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    slab_next  = '0;
                    start_next = base_a;
                    faddr_next = addr_a;
                    state_next = (cmd_t'(cmd) == CMD_FREE) ? S_F_SCAN : S_A_RD;
                end
            end
            S_A_RD:
            begin
                priority if (slab_open)
                    state_next = S_A_CHK;
                else if (in_use_reg < SUW'(MAX_SLABS))
                begin
                    // open a new slab and pop its top object at once
                    cnt_we          = 1'b1;
                    cnt_wdata.count = n_last;
                    cnt_wdata.mark  = n_last;
                    pos_next        = n_last;
                    use_pos_next    = 1'b1;
                    in_use_next     = in_use_reg + SUW'(1);
                    state_next      = S_A_MUL;
                end
                else
                begin
                    res_addr_next   = '0;
                    res_status_next = ST_OOM;
                    state_next      = S_DONE;
                end
            end
            S_A_CHK:
            begin
                if (cnt_rd_reg.count != '0)
                begin
                    stk_pos         = pop_c;
                    cnt_we          = 1'b1;
                    cnt_wdata.count = pop_c;
                    cnt_wdata.mark  = pop_fresh ? pop_c : cnt_rd_reg.mark;
                    pos_next        = pop_c;
                    use_pos_next    = pop_fresh;
                    state_next      = S_A_MUL;
                end
                else
                begin
                    slab_next  = slab_reg + SUW'(1);
                    start_next = step64[AW-1:0];
                    state_next = S_A_RD;
                end
            end
            S_A_MUL:
            begin
                prod_next  = PRW'(idx) * PRW'(obj_eff);
                state_next = S_A_ADD;
            end
            S_A_ADD:
            begin
                res_addr_next   = sum64[AW-1:0];
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end
            S_F_SCAN:
            begin
                priority if (!slab_open)
                begin
                    res_addr_next   = '0;
                    res_status_next = ST_NOT_IN_SLAB;
                    state_next      = S_DONE;
                end
                else if (in_slab)
                begin
                    div_start  = 1'b1;
                    state_next = S_F_DIV;
                end
                else
                begin
                    slab_next  = slab_reg + SUW'(1);
                    start_next = step64[AW-1:0];
                end
            end
            S_F_DIV:
            begin
                stk_pos = cnt_rd_reg.count;
                if (div_done)
                begin
                    res_addr_next = '0;
                    priority if (div_rem != '0)
                        res_status_next = ST_UNALIGNED;
                    else if (div_quot >= SLAB_W'(n_eff) || cnt_rd_reg.count >= n_eff)
                        res_status_next = ST_INVALID;
                    else
                    begin
                        // push the index onto the slab's stack
                        stk_we          = 1'b1;
                        cnt_we          = 1'b1;
                        cnt_wdata.count = cnt_rd_reg.count + CW'(1);
                        res_status_next = ST_OK;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        obj_addr_next  = obj_addr_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            obj_addr_next  = res_addr_reg;
            status_next    = res_status_reg;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_use_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slab_reg       <= slab_next;
        start_reg      <= start_next;
        faddr_reg      <= faddr_next;
        pos_reg        <= pos_next;
        use_pos_reg    <= use_pos_next;
        prod_reg       <= prod_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        obj_addr_reg   <= obj_addr_next;
        status_reg     <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_addr] <= cnt_wdata;
        cnt_rd_reg <= cnt_mem[cnt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_addr] <= stk_wdata;
        stk_rd_reg <= stk_mem[stk_addr];
    end

    logic [63:0] obj64;

    assign obj64     = 64'(obj_addr_reg);
    assign obj_addr  = obj64[PORT_AW-1:0];
    assign status    = status_reg;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == S_IDLE);

endmodule

FILE: src/soa_cfg.sv
`timescale 1ns / 1ps

module soa_cfg
    import soa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region_base      <= RST_REGION_BASE;
            cfg_reg.object_size      <= RST_OBJECT_SIZE;
            cfg_reg.slab_size        <= RST_SLAB_SIZE;
            cfg_reg.objects_per_slab <= RST_OBJECTS_PER_SLAB;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_REGION_BASE:      cfg_reg.region_base      <= pwdata[BASE_W-1:0];
                REG_OBJECT_SIZE:      cfg_reg.object_size      <= pwdata[OBJ_SIZE_W-1:0];
                REG_SLAB_SIZE:        cfg_reg.slab_size        <= pwdata[SLAB_W-1:0];
                REG_OBJECTS_PER_SLAB: cfg_reg.objects_per_slab <= pwdata[OPS_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_REGION_BASE:      prdata = DATA_W'(cfg_reg.region_base);
            REG_OBJECT_SIZE:      prdata = DATA_W'(cfg_reg.object_size);
            REG_SLAB_SIZE:        prdata = DATA_W'(cfg_reg.slab_size);
            REG_OBJECTS_PER_SLAB: prdata = DATA_W'(cfg_reg.objects_per_slab);
        endcase
    end

endmodule

FILE: src/soa_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module soa_div
    import soa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SLAB_W-1:0]     dividend,
    input  logic [OBJ_SIZE_W-1:0] divisor,
    output logic                  done,
    output logic [SLAB_W-1:0]     quot,
    output logic [OBJ_SIZE_W-1:0] rem
);

    localparam int CNT_W = $clog2(SLAB_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SLAB_W-1:0]     dvd_reg, dvd_next;
    logic [OBJ_SIZE_W-1:0] rem_reg, rem_next;
    logic [OBJ_SIZE_W-1:0] dsr_reg, dsr_next;
    logic [OBJ_SIZE_W:0]   trial;
    logic [OBJ_SIZE_W:0]   diff;
    logic                  ge;

    assign trial = {rem_reg, dvd_reg[SLAB_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNT_W'(SLAB_W);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift the quotient bit in where the dividend bit leaves
            dvd_next = {dvd_reg[SLAB_W-2:0], ge};
            rem_next = ge ? diff[OBJ_SIZE_W-1:0] : trial[OBJ_SIZE_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quot = dvd_reg;
    assign rem  = rem_reg;

endmodule

FILE: tb/slab_object_allocator_top_test.sv
`timescale 1ns / 1ps

module slab_object_allocator_top_test
    import soa_pkg::*;
();

    localparam int SLAB_COUNT     = 16;
    localparam int SLAB_OBJECTS   = 256;
    localparam int AW             = PORT_AW;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 56;

    typedef enum int {
        GEOM_TIGHT,
        GEOM_MID,
        GEOM_EXTREME,
        GEOM_DEGENERATE,
        GEOM_ANY
    } geom_kind_t;

    typedef struct {
        cmd_t          op;
        logic [AW-1:0] addr;
    } heap_req_t;

    typedef struct {
        cmd_t          op;
        logic [AW-1:0] obj_addr;
        status_t       status;
    } heap_resp_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               cmd = 1'b0;
    logic [AW-1:0]      addr = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [AW-1:0]      obj_addr;
    logic [2:0]         status;

    // shadow of the allocator
    cfg_t               heap_cfg;
    int unsigned        open_slabs;
    int unsigned        free_depth [SLAB_COUNT];
    logic [7:0]         free_list  [SLAB_COUNT][SLAB_OBJECTS];

    heap_req_t          pending_reqs [$];
    heap_resp_t         expected_resps [$];
    heap_resp_t         want;
    int unsigned        source_idle_pct = 0;
    int unsigned        sink_stall_pct = 0;
    int                 hold_requests = 0;
    int                 hold_served = 0;
    int                 hold_left = 0;
    int                 quiet_cycles = 0;
    int                 errors = 0;
    int unsigned        accepted = 0;
    int unsigned        tally [2][8];

    geom_kind_t  phase_geom [PHASES] = '{GEOM_TIGHT, GEOM_TIGHT, GEOM_TIGHT, GEOM_MID,
                                         GEOM_EXTREME, GEOM_DEGENERATE, GEOM_TIGHT, GEOM_ANY};
    int unsigned phase_alloc_pct [PHASES] = '{85, 80, 75, 50, 50, 50, 60, 50};

    slab_object_allocator_top #(
        .MAX_SLABS(SLAB_COUNT),
        .MAX_OBJECTS_PER_SLAB(SLAB_OBJECTS),
        .ADDR_WIDTH(AW)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .addr(addr),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .obj_addr(obj_addr),
        .status(status)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [AW-1:0] obj_bytes();
        return (heap_cfg.object_size == '0) ? AW'(1) : AW'(heap_cfg.object_size);
    endfunction

    function automatic logic [AW-1:0] slab_bytes();
        return (heap_cfg.slab_size == '0) ? AW'(1) : AW'(heap_cfg.slab_size);
    endfunction

    function automatic int unsigned objs_per_slab();
        if (heap_cfg.objects_per_slab == '0)
            return 1;
        if (heap_cfg.objects_per_slab > SLAB_OBJECTS)
            return SLAB_OBJECTS;
        return int'(heap_cfg.objects_per_slab);
    endfunction

    function automatic logic [AW-1:0] slab_start(int unsigned s);
        return heap_cfg.region_base + AW'(s) * slab_bytes();
    endfunction

    function automatic logic [AW-1:0] pop_object(int unsigned s);
        logic [7:0] idx;
        free_depth[s] = free_depth[s] - 1;
        idx = free_list[s][free_depth[s]];
        return slab_start(s) + AW'(idx) * obj_bytes();
    endfunction

    function automatic heap_resp_t predict_heap(heap_req_t req);
        heap_resp_t    r;
        logic [AW-1:0] off;
        int unsigned   n;
        int unsigned   s;
        int unsigned   i;
        bit            done;
        r.op = req.op;
        r.obj_addr = '0;
        r.status = ST_OK;
        n = objs_per_slab();
        done = 1'b0;
        if (req.op == CMD_ALLOC)
        begin
            for (s = 0; s < open_slabs; s++)
            begin
                if (!done && free_depth[s] != 0)
                begin
                    r.obj_addr = pop_object(s);
                    done = 1'b1;
                end
            end
            if (!done)
            begin
                if (open_slabs < SLAB_COUNT)
                begin
                    for (i = 0; i < n; i++)
                        free_list[open_slabs][i] = 8'(i);
                    free_depth[open_slabs] = n;
                    open_slabs = open_slabs + 1;
                    r.obj_addr = pop_object(open_slabs - 1);
                end
                else
                    r.status = ST_OOM;
            end
        end
        else
        begin
            r.status = ST_NOT_IN_SLAB;
            // lowest open slab holding the address decides
            for (s = 0; s < open_slabs; s++)
            begin
                off = req.addr - slab_start(s);
                if (!done && off < slab_bytes())
                begin
                    done = 1'b1;
                    if (off % obj_bytes() != 0)
                        r.status = ST_UNALIGNED;
                    else if (off / obj_bytes() >= n || free_depth[s] >= n)
                        r.status = ST_INVALID;
                    else
                    begin
                        free_list[s][free_depth[s]] = 8'(off / obj_bytes());
                        free_depth[s] = free_depth[s] + 1;
                        r.status = ST_OK;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] pick_free_addr();
        logic [AW-1:0] osz;
        int unsigned   n;
        int unsigned   s;
        int unsigned   k;
        int unsigned   r;
        osz = obj_bytes();
        n = objs_per_slab();
        if (open_slabs != 0 && $urandom_range(99) < 80)
            s = $urandom_range(open_slabs - 1);
        else
            s = $urandom_range(SLAB_COUNT - 1);
        k = $urandom_range(n - 1);
        r = $urandom_range(99);
        if (r < 66)
            return slab_start(s) + AW'(k) * osz;
        if (r < 74)
            return slab_start(s) + AW'(n) * osz;
        if (r < 86)
            return slab_start(s) + AW'(k) * osz
                   + AW'($urandom_range((osz > 1) ? osz - 1 : 1, 1));
        if (r < 92)
            return slab_start(s) - 1;
        if (r < 96)
            return slab_start(s) + slab_bytes() - 1;
        return $urandom();
    endfunction

    task automatic queue_req(cmd_t op, logic [AW-1:0] a);
        heap_req_t req;
        req.op = op;
        req.addr = a;
        pending_reqs.insert(pending_reqs.size(), req);
    endtask

    task automatic write_reg(reg_idx_t r, logic [DATA_W-1:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * int'(r));
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_REGION_BASE:      heap_cfg.region_base = v[BASE_W-1:0];
            REG_OBJECT_SIZE:      heap_cfg.object_size = v[OBJ_SIZE_W-1:0];
            REG_SLAB_SIZE:        heap_cfg.slab_size = v[SLAB_W-1:0];
            REG_OBJECTS_PER_SLAB: heap_cfg.objects_per_slab = v[OPS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [31:0] base, logic [31:0] osz, logic [31:0] slab,
                                logic [31:0] n);
        write_reg(REG_REGION_BASE, base);
        write_reg(REG_OBJECT_SIZE, osz);
        write_reg(REG_SLAB_SIZE, slab);
        write_reg(REG_OBJECTS_PER_SLAB, n);
    endtask

    task automatic program_geometry(geom_kind_t kind);
        logic [31:0] osz;
        logic [31:0] n;
        case (kind)
            GEOM_TIGHT:
            begin
                n = $urandom_range(6, 1);
                osz = $urandom_range(256, 1);
                set_geometry($urandom(), osz, n * osz + $urandom_range(2 * osz, 0), n);
            end
            GEOM_MID:
            begin
                n = $urandom_range(64, 8);
                osz = $urandom_range(128, 8);
                set_geometry($urandom() & 32'hFFFF_F000, osz, n * osz, n);
            end
            GEOM_EXTREME:
                set_geometry(32'hFFFF_FFFF - $urandom_range(4096, 0), 32'h0000_FFFF,
                             32'h00FF_FFFF, $urandom_range(1) ? 32'd256 : 32'h1FF);
            GEOM_DEGENERATE:
                set_geometry($urandom(), $urandom_range(1, 0), $urandom_range(1, 0),
                             $urandom_range(1, 0));
            default:
                set_geometry($urandom(), $urandom() & 32'hFFFF, $urandom() & 32'hFF_FFFF,
                             $urandom() & 32'h1FF);
        endcase
    endtask

    task automatic queue_random_phase(int unsigned count, int unsigned alloc_pct);
        int unsigned i;
        for (i = 0; i < count; i++)
        begin
            // keep the queue short so free targets track the open slabs
            while (pending_reqs.size() >= 4)
                @(posedge clk);
            if ($urandom_range(99) < alloc_pct)
                queue_req(CMD_ALLOC, $urandom());
            else
                queue_req(CMD_FREE, pick_free_addr());
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= source_idle_pct)
            begin
                in_valid <= 1'b1;
                cmd <= pending_reqs[0].op;
                addr <= pending_reqs[0].addr;
                void'(pending_reqs.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result sink
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // check results first, then predict the newly accepted request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_resps.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: obj_addr=%h status=%0d", obj_addr, status);
                end
                else
                begin
                    want = expected_resps.pop_front();
                    tally[int'(want.op)][int'(want.status)]++;
                    if (obj_addr !== want.obj_addr || status !== want.status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch (%s): expected obj_addr=%h status=%0d, got obj_addr=%h status=%0d",
                                     want.op.name(), want.obj_addr, want.status, obj_addr, status);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_resps.insert(expected_resps.size(),
                                      predict_heap('{op: cmd_t'(cmd), addr: addr}));
                accepted++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL slab_object_allocator_top");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int ph;
        heap_cfg = '{RST_REGION_BASE, RST_OBJECT_SIZE, RST_SLAB_SIZE, RST_OBJECTS_PER_SLAB};
        open_slabs = 0;
        foreach (free_depth[i])
            free_depth[i] = 0;
        foreach (tally[i, j])
            tally[i][j] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: 64 objects of 64 bytes in each 4 KiB slab
        queue_req(CMD_ALLOC, '0);
        queue_req(CMD_ALLOC, '1);
        queue_req(CMD_FREE, 32'd4032);
        queue_req(CMD_FREE, 32'd4032);          // double free, stack not yet full
        queue_req(CMD_FREE, 32'd3968);          // stack full
        queue_req(CMD_FREE, 32'd4033);
        queue_req(CMD_FREE, 32'd4096);
        queue_req(CMD_FREE, 32'hFFFF_FFFF);
        queue_req(CMD_ALLOC, '0);
        wait_idle();

        // widest geometry, slab 0 wraps past the top of the address space
        set_geometry(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h00FF_FFFF, 32'h1FF);
        queue_req(CMD_FREE, 32'hFFFF_FFFF);
        queue_req(CMD_FREE, 32'hFFFF_FFFF + 32'd255 * 32'hFFFF);
        queue_req(CMD_FREE, 32'hFFFF_FFFF + 32'd256 * 32'hFFFF);   // index past the last object
        queue_req(CMD_FREE, 32'h0);
        queue_req(CMD_FREE, 32'hFFFF_FFFF + 32'h00FF_FFFF);
        queue_req(CMD_ALLOC, '1);
        wait_idle();

        // zero sizes and zero count all act as one
        set_geometry(32'h0, 32'h0, 32'h0, 32'h0);
        queue_req(CMD_FREE, 32'h0);             // stack deeper than the lowered count
        queue_req(CMD_FREE, 32'h1);
        queue_req(CMD_ALLOC, '0);
        wait_idle();

        for (ph = 0; ph < PHASES; ph++)
        begin
            program_geometry(phase_geom[ph]);
            source_idle_pct = (ph % 4 == 1) ? 46 : (ph % 4 == 3) ? 31 : 0;
            sink_stall_pct = (ph % 4 == 2) ? 46 : (ph % 4 == 3) ? 31 : 0;
            // hold off the sink so the allocator backs up into its input
            if (ph == 4)
                hold_requests++;
            queue_random_phase(PHASE_ITEMS, phase_alloc_pct[ph]);
            wait_idle();
        end

        $display("%0d transactions over %0d geometries, %0d slabs opened",
                 accepted, PHASES + 3, open_slabs);
        $display("allocs: %0d served, %0d out of memory; frees: %0d ok, %0d unaligned, %0d outside, %0d rejected",
                 tally[CMD_ALLOC][ST_OK], tally[CMD_ALLOC][ST_OOM], tally[CMD_FREE][ST_OK],
                 tally[CMD_FREE][ST_UNALIGNED], tally[CMD_FREE][ST_NOT_IN_SLAB],
                 tally[CMD_FREE][ST_INVALID]);
        if (errors == 0 && expected_resps.size() == 0)
            $display("PASS slab_object_allocator_top");
        else
            $display("FAIL slab_object_allocator_top");
        $finish;
    end

endmodule
